// ===== hdl/trwr_pkg.sv =====
// ----------------------------------------------------------------------------
// trwr_pkg
// Shared types and constants for the trie root word replacer.
// ----------------------------------------------------------------------------
package trwr_pkg;

  // Node table size and letter alphabet
  localparam int NODES       = 1024;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(NODES);
  localparam int FREE_W      = NODE_W + 1;
  localparam int CHILD_DEPTH = NODES * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int LETTER_W    = $clog2(ALPHABET);

  // Character codes
  localparam logic [7:0] LETTER_A   = 8'd97;
  localparam logic [7:0] LETTER_END = LETTER_A + 8'(ALPHABET);
  localparam logic [7:0] SPACE_CH   = 8'd32;

  // Request kinds carried on tuser
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ROOT  = 2'd1,
    CMD_SENT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Per-word walk mode
  typedef enum logic [1:0] {
    MODE_WALK     = 2'd0,
    MODE_SUPPRESS = 2'd1,
    MODE_PASS     = 2'd2
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

endpackage

// ===== hdl/trie_root_word_replacer_unit.sv =====
// ----------------------------------------------------------------------------
// trie_root_word_replacer_unit
// Loads lower-case roots into a trie node table and cuts each sentence word
// back to the shortest stored root that is its prefix.
// ----------------------------------------------------------------------------
// Each accepted request is captured with its memory reads, then executed in
//   ST_EXEC, which registers its result; s_tready is high only in ST_IDLE.
//   A root character that allocates a node also passes ST_CLEAR, since the new
//   node's mask is cleared through the single mask memory write port.
//   Execute also waits while the previous result is held by m_tready.
// Reset: synchronous rst empties the dictionary at once; no clearing pass.
//   The root node mask lives in flip-flops; other nodes are cleared on use.
// ----------------------------------------------------------------------------
module trie_root_word_replacer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic [1:0]  s_tuser,   // [1:0] command
  input  logic        s_tlast,   // root_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] out_valid, [8:1] out_char, [9] status
);
  import trwr_pkg::*;

  // Control state
  state_t               state, state_next;
  logic [ALPHABET-1:0]  root_mask, root_mask_next;
  logic [FREE_W-1:0]    next_free, next_free_next;
  logic [NODE_W-1:0]    load_cursor, load_cursor_next;
  logic [NODE_W-1:0]    walk_cursor, walk_cursor_next;
  mode_t                word_mode, word_mode_next;
  logic                 load_overflow, load_overflow_next;
  logic                 root_bad, root_bad_next;

  // Captured request
  cmd_t                 item_cmd;
  logic [7:0]           item_ch;
  logic                 item_last;
  logic                 item_letter;
  logic [LETTER_W-1:0]  item_idx;
  logic [NODE_W-1:0]    item_node;
  logic [CHILD_AW-1:0]  item_addr;
  logic [NODE_W-1:0]    alloc_node;

  // Memories and their read registers
  logic [ALPHABET-1:0]  mask_mem [NODES];
  logic [NODE_W:0]      child_mem [CHILD_DEPTH];
  logic [ALPHABET-1:0]  rd_mask;
  logic [NODE_W:0]      rd_child;

  logic                 mask_we;
  logic [NODE_W-1:0]    mask_wa;
  logic [ALPHABET-1:0]  mask_wd;
  logic                 child_we;
  logic [NODE_W:0]      child_wd;
  logic                 alloc_set;

  // Request decode
  logic                 in_accept;
  logic                 in_letter;
  logic [LETTER_W-1:0]  in_idx;
  logic [NODE_W-1:0]    in_node;
  logic [CHILD_AW-1:0]  in_addr;

  // Execute-side signals
  logic                 out_free;
  logic                 push;
  logic [15:0]          res;
  logic [ALPHABET-1:0]  node_mask;
  logic [ALPHABET-1:0]  letter_bit;
  logic                 hit;
  logic                 child_end;
  logic [NODE_W-1:0]    child_node;
  logic [NODE_W-1:0]    new_node;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_letter = (s_tdata >= LETTER_A) && (s_tdata < LETTER_END);
  assign in_idx    = in_letter ? LETTER_W'(s_tdata - LETTER_A) : '0;
  assign in_node   = (cmd_t'(s_tuser) == CMD_ROOT) ? load_cursor : walk_cursor;
  assign in_addr   = CHILD_AW'(in_node) * CHILD_AW'(ALPHABET) + CHILD_AW'(in_idx);

  assign out_free   = !m_tvalid || m_tready;
  assign node_mask  = (item_node == '0) ? root_mask : rd_mask;
  assign letter_bit = ALPHABET'(1) << item_idx;
  assign hit        = item_letter && node_mask[item_idx];
  assign child_end  = rd_child[NODE_W];
  assign child_node = rd_child[NODE_W-1:0];
  assign new_node   = next_free[NODE_W-1:0];

  // Mask memory: one write, one registered read at accept
  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[mask_wa] <= mask_wd;
    end
    if (in_accept) begin
      rd_mask <= mask_mem[in_node];
    end
  end

  // Child memory: {end flag of child, child node} per (node, letter) edge
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[item_addr] <= child_wd;
    end
    if (in_accept) begin
      rd_child <= child_mem[in_addr];
    end
  end

  // Sequencer and trie update
  always_comb begin
    state_next         = state;
    root_mask_next     = root_mask;
    next_free_next     = next_free;
    load_cursor_next   = load_cursor;
    walk_cursor_next   = walk_cursor;
    word_mode_next     = word_mode;
    load_overflow_next = load_overflow;
    root_bad_next      = root_bad;
    mask_we            = 1'b0;
    mask_wa            = item_node;
    mask_wd            = node_mask | letter_bit;
    child_we           = 1'b0;
    child_wd           = {item_last, child_node};
    alloc_set          = 1'b0;
    push               = 1'b0;
    res                = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
          push       = 1'b1;
          unique case (item_cmd)
            CMD_CLEAR: begin
              root_mask_next     = '0;
              next_free_next     = FREE_W'(1);
              load_cursor_next   = '0;
              walk_cursor_next   = '0;
              word_mode_next     = MODE_WALK;
              load_overflow_next = 1'b0;
              root_bad_next      = 1'b0;
            end
            CMD_ROOT: begin
              if (load_overflow) begin
                res[9] = 1'b1;
              end else if (!root_bad) begin
                if (!item_letter) begin
                  root_bad_next = 1'b1;
                end else if (hit) begin
                  load_cursor_next = child_node;
                  // root ends on an existing node: mark it in its edge
                  if (item_last) begin
                    child_we = 1'b1;
                    child_wd = {1'b1, child_node};
                  end
                end else if (next_free >= FREE_W'(NODES)) begin
                  load_overflow_next = 1'b1;
                  res[9]             = 1'b1;
                end else begin
                  // allocate a node and link it under the current one
                  child_we         = 1'b1;
                  child_wd         = {item_last, new_node};
                  alloc_set        = 1'b1;
                  next_free_next   = next_free + FREE_W'(1);
                  load_cursor_next = new_node;
                  state_next       = ST_CLEAR;
                  if (item_node == '0) begin
                    root_mask_next = node_mask | letter_bit;
                  end else begin
                    mask_we = 1'b1;
                  end
                end
              end
              if (item_last) begin
                load_cursor_next   = '0;
                load_overflow_next = 1'b0;
                root_bad_next      = 1'b0;
              end
            end
            CMD_SENT: begin
              if (item_ch == SPACE_CH) begin
                walk_cursor_next = '0;
                word_mode_next   = MODE_WALK;
                res[8:0]         = {item_ch, 1'b1};
              end else begin
                unique case (word_mode)
                  MODE_SUPPRESS: begin
                    res = '0;
                  end
                  MODE_WALK: begin
                    if (hit) begin
                      walk_cursor_next = child_node;
                      if (child_end) begin
                        word_mode_next = MODE_SUPPRESS;
                      end
                    end else begin
                      word_mode_next = MODE_PASS;
                    end
                    res[8:0] = {item_ch, 1'b1};
                  end
                  default: begin
                    res[8:0] = {item_ch, 1'b1};
                  end
                endcase
              end
            end
            CMD_NONE: begin
              res = '0;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        // fresh node starts with no children
        mask_we    = 1'b1;
        mask_wa    = alloc_node;
        mask_wd    = '0;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      root_mask     <= '0;
      next_free     <= FREE_W'(1);
      load_cursor   <= '0;
      walk_cursor   <= '0;
      word_mode     <= MODE_WALK;
      load_overflow <= 1'b0;
      root_bad      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      root_mask     <= root_mask_next;
      next_free     <= next_free_next;
      load_cursor   <= load_cursor_next;
      walk_cursor   <= walk_cursor_next;
      word_mode     <= word_mode_next;
      load_overflow <= load_overflow_next;
      root_bad      <= root_bad_next;
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_cmd    <= cmd_t'(s_tuser);
      item_ch     <= s_tdata;
      item_last   <= s_tlast;
      item_letter <= in_letter;
      item_idx    <= in_idx;
      item_node   <= in_node;
      item_addr   <= in_addr;
    end
    if (alloc_set) begin
      alloc_node <= new_node;
    end
    if (push) begin
      m_tdata <= res;
    end
  end

  // Checks
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free != '0) && (next_free <= FREE_W'(NODES)))
    else $error("next free node out of range");

  a_clear_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> ($past(state) == ST_EXEC))
    else $error("node clear cycle without a preceding allocation");

  a_exec_pushes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && out_free) |=> m_tvalid)
    else $error("executed request produced no result");

  a_status_root_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> !m_tdata[0])
    else $error("table full status on a sentence character");

endmodule
